FILE: design/mspq_pkg.sv
package mspq_pkg;

  localparam int CAPACITY = 1024;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENTRY_COUNT_W = 11;
  localparam int SCORE_W = 31;
  localparam int NODE_W = 32;
  localparam int KEY_W = SCORE_W + NODE_W;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [NODE_W-1:0]  node_index;
    logic [SCORE_W-1:0] score;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [NODE_W-1:0]        top_node;
    logic [SCORE_W-1:0]       top_score;
    logic                     is_empty;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } chain_ctl_t;

  // larger key is higher priority; ties on score go to the smaller node
  function automatic key_t make_key(logic [SCORE_W-1:0] score, logic [NODE_W-1:0] node);
    make_key = {score, ~node};
  endfunction

endpackage

FILE: design/max_score_priority_queue_unit.sv
// Max-score priority queue of (score, node index) entries.
// Request channel req_valid/req_ready/req carries one command per item:
// push an entry, pop the highest entry, or peek at it. Response channel
// rsp_valid/rsp_ready/rsp returns exactly one item per request, in order.
// Highest means largest score; equal scores favor the smaller node index.
// Storage is a sorted chain of CAPACITY cells: a push inserts in place
// with all lower cells stepping one place down, a pop steps every cell
// one place up. The response is registered in the cycle after the request
// is accepted, and a new request can be taken every cycle while the
// receiver does not stall the response channel.
// The response sits in a single output register; while the receiver
// stalls, req_ready stays low and nothing is lost.
// Reset empties the queue at once (count cleared, no clearing pass) and
// drops any pending response.
// A push to a full queue answers status full and drops the entry; pop or
// peek on an empty queue answers status empty with zero node and score.
module max_score_priority_queue_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mspq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mspq_pkg::rsp_t rsp
);
  import mspq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_zero;
  logic             do_push;
  logic             do_pop;
  chain_ctl_t       ctl;
  key_t             head_key;
  key_t             second_key;
  rsp_t             rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_full   = count == CNT_W'(CAPACITY);
  assign is_zero   = count == '0;
  assign do_push   = accept && (req.cmd == CMD_PUSH) && !is_full;
  assign do_pop    = accept && (req.cmd == CMD_POP) && !is_zero;

  assign ctl.push = do_push;
  assign ctl.pop  = do_pop;
  assign ctl.key  = make_key(req.score, req.node_index);

  mspq_chain u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .count      (count),
    .head_key   (head_key),
    .second_key (second_key)
  );

  always_comb begin
    count_next = count;
    if (do_push) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop) begin
      count_next = count - CNT_W'(1);
    end

    rsp_next.status    = ST_OK;
    rsp_next.top_node  = '0;
    rsp_next.top_score = '0;
    unique case (req.cmd)
      CMD_PUSH: begin
        if (is_full) begin
          rsp_next.status = ST_FULL;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (is_zero) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.top_node  = ~head_key[NODE_W-1:0];
          rsp_next.top_score = head_key[KEY_W-1:NODE_W];
        end
      end
      default: begin
      end
    endcase
    rsp_next.is_empty    = count_next == '0;
    rsp_next.entry_count = ENTRY_COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    accept && (req.cmd == CMD_PUSH) && is_full |=> rsp.status == ST_FULL
      && count == $past(count))
    else $error("push on full queue not rejected");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    accept && (req.cmd == CMD_POP || req.cmd == CMD_PEEK) && is_zero
      |=> rsp.status == ST_EMPTY && rsp.is_empty)
    else $error("pop or peek on empty queue not flagged");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> head_key >= second_key)
    else $error("chain head out of order");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not decrement count");

endmodule

FILE: design/mspq_cell.sv
module mspq_cell (
  input  logic               clk,
  input  mspq_pkg::chain_ctl_t ctl,
  input  logic               occ,
  input  logic               prev_ins,
  input  mspq_pkg::key_t     prev_key,
  input  mspq_pkg::key_t     next_key,
  output mspq_pkg::key_t     key,
  output logic               ins
);
  import mspq_pkg::*;

  // new key belongs at or before this cell
  assign ins = !occ || (ctl.key > key);

  always_ff @(posedge clk) begin
    if (ctl.push && ins) begin
      key <= prev_ins ? prev_key : ctl.key;
    end else if (ctl.pop) begin
      key <= next_key;
    end
  end

endmodule

FILE: design/mspq_chain.sv
module mspq_chain (
  input  logic                    clk,
  input  mspq_pkg::chain_ctl_t    ctl,
  input  logic [mspq_pkg::CNT_W-1:0] count,
  output mspq_pkg::key_t          head_key,
  output mspq_pkg::key_t          second_key
);
  import mspq_pkg::*;

  key_t keys [CAPACITY];
  logic ins  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ;
    logic p_ins;
    key_t p_key;
    key_t n_key;

    assign occ = count > CNT_W'(i);

    if (i == 0) begin : g_first
      assign p_ins = 1'b0;
      assign p_key = '0;
    end else begin : g_mid
      assign p_ins = ins[i-1];
      assign p_key = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_key = '0;
    end else begin : g_next
      assign n_key = keys[i+1];
    end

    mspq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ),
      .prev_ins (p_ins),
      .prev_key (p_key),
      .next_key (n_key),
      .key      (keys[i]),
      .ins      (ins[i])
    );
  end

  assign head_key   = keys[0];
  assign second_key = keys[1];

endmodule
